// ===== hdl/c2s_pkg.sv =====
// ---------------------------------------------------------------------------
// c2s_pkg: shared types and constants of the Cartesian-to-spherical converter
// Item layouts, internal widths and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package c2s_pkg;

    // Coordinate and difference widths.
    localparam int CRD_W  = 24;
    localparam int DIFF_W = CRD_W + 1;
    localparam int SQ_W   = 2 * CRD_W + 1;
    localparam int R2_W   = 2 * CRD_W + 2;

    // Square root: radicand scaled by 2^(2*SQ_FRAC), one root bit per cell.
    localparam int SQ_FRAC  = 28;
    localparam int ROOT_W   = (R2_W + 2 * SQ_FRAC) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 1;
    localparam int SQ_STEPS = ROOT_W;
    localparam int RNG_W    = ROOT_W + 1 - SQ_FRAC;

    // Operand normalization to a leading one at bit NRM_W-1.
    localparam int NRM_W     = 59;
    localparam int NRM_STEPS = 6;
    localparam int NSH_W     = 6;
    localparam int NRM_FIRST = 32;

    // CORDIC datapath.
    localparam int CRD_STEPS = 40;
    localparam int STEP_W    = $clog2(CRD_STEPS);
    localparam int CX_W      = 62;
    localparam int TAB_W     = 40;
    localparam int Z_W       = TAB_W + 1;
    localparam int Z_FRAC    = 32;

    // Result formats.
    localparam int ANG_FRAC = 16;
    localparam int ANG_W    = ANG_FRAC + 8;
    localparam int RANGE_W  = 25;
    localparam int RND_SH   = Z_FRAC - ANG_FRAC;

    localparam logic [ANG_W-1:0] RIGHT_ANGLE     = ANG_W'(90) << ANG_FRAC;
    localparam logic [ANG_W-1:0] NEG_RIGHT_ANGLE = ANG_W'(0) - RIGHT_ANGLE;

    // 180/pi with 32 fraction bits.
    localparam logic [127:0] DEG_PER_RAD_Q32 = 128'd246083499208;

    typedef struct packed {
        logic signed [CRD_W-1:0] src_x;
        logic signed [CRD_W-1:0] src_y;
        logic signed [CRD_W-1:0] src_z;
        logic signed [CRD_W-1:0] dst_x;
        logic signed [CRD_W-1:0] dst_y;
        logic signed [CRD_W-1:0] dst_z;
    } c2s_pos_t;

    typedef struct packed {
        logic        [RANGE_W-1:0] range_out;
        logic signed [ANG_W-1:0]   azimuth_deg;
        logic signed [ANG_W-1:0]   elevation_deg;
        logic                      undefined_flag;
    } c2s_sph_t;

    // Per-item facts that travel alongside the arithmetic lanes.
    typedef struct packed {
        logic [DIFF_W-1:0]  ax;
        logic [DIFF_W-1:0]  ay;
        logic [DIFF_W-1:0]  az;
        logic               azi_neg;
        logic               dx_zero;
        logic               dy_zero;
        logic               dy_neg;
        logic               dz_zero;
        logic               dz_neg;
        logic [RANGE_W-1:0] rng;
    } c2s_side_t;

    // atan(2^-i) in radians with 62 fraction bits, truncated power series.
    function automatic logic [63:0] atan_pow2_q62(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned e;
        int unsigned k;
        acc = '0;
        for (k = 0; k < 32; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 62)
            begin
                term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                if (k[0])
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        return acc;
    endfunction

    // atan(1/3) in radians with 62 fraction bits.
    function automatic logic [63:0] atan_third_q62();
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned k;
        p   = (64'd1 << 62) / 64'd3;
        acc = '0;
        for (k = 0; k < 32; k++)
        begin
            if (p != 64'd0)
            begin
                term = p / 64'(2 * k + 1);
                if (k[0])
                    acc = acc - term;
                else
                    acc = acc + term;
                p = p / 64'd9;
            end
        end
        return acc;
    endfunction

    // Rotation angle of step i in degrees with 32 fraction bits, rounded.
    function automatic logic [TAB_W-1:0] atan_entry(input int unsigned i);
        logic [63:0]  rad;
        logic [127:0] prod;
        if (i == 0)
            rad = atan_pow2_q62(1) + atan_third_q62();
        else
            rad = atan_pow2_q62(i);
        prod = {64'd0, rad} * DEG_PER_RAD_Q32 + (128'd1 << 61);
        return prod[62 +: TAB_W];
    endfunction

endpackage

// ===== hdl/c2s_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// c2s_sqrt_cell: one digit of a restoring square root
// Brings down two radicand bits and decides one root bit per cycle while en is high.
// ---------------------------------------------------------------------------
module c2s_sqrt_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [c2s_pkg::RAD_W-1:0]     rad_in,
    input  logic [c2s_pkg::ROOT_W-1:0]    root_in,
    input  logic [c2s_pkg::REM_W-1:0]     rem_in,
    output logic [c2s_pkg::RAD_W-1:0]     rad_out,
    output logic [c2s_pkg::ROOT_W-1:0]    root_out,
    output logic [c2s_pkg::REM_W-1:0]     rem_out
);

    logic [c2s_pkg::REM_W+1:0]  cur;
    logic [c2s_pkg::REM_W+1:0]  trial;
    logic [c2s_pkg::REM_W+1:0]  diff;
    logic                       ge;
    logic [c2s_pkg::RAD_W-1:0]  rad_reg;
    logic [c2s_pkg::RAD_W-1:0]  rad_next;
    logic [c2s_pkg::ROOT_W-1:0] root_reg;
    logic [c2s_pkg::ROOT_W-1:0] root_next;
    logic [c2s_pkg::REM_W-1:0]  rem_reg;
    logic [c2s_pkg::REM_W-1:0]  rem_next;

    always_comb
    begin
        cur       = {rem_in, rad_in[c2s_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = (cur >= trial);
        diff      = cur - trial;
        rem_next  = ge ? diff[c2s_pkg::REM_W-1:0] : cur[c2s_pkg::REM_W-1:0];
        root_next = {root_in[c2s_pkg::ROOT_W-2:0], ge};
        rad_next  = {rad_in[c2s_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule

// ===== hdl/c2s_norm_cell.sv =====
// ---------------------------------------------------------------------------
// c2s_norm_cell: one step of operand normalization
// Shifts an operand pair left by a fixed amount when its top bits are clear.
// ---------------------------------------------------------------------------
module c2s_norm_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [c2s_pkg::NSH_W-1:0]   sh,
    input  logic [c2s_pkg::NRM_W-1:0]   x_in,
    input  logic [c2s_pkg::NRM_W-1:0]   y_in,
    output logic [c2s_pkg::NRM_W-1:0]   x_out,
    output logic [c2s_pkg::NRM_W-1:0]   y_out
);

    logic [c2s_pkg::NRM_W-1:0] hi_mask;
    logic                      move;
    logic [c2s_pkg::NRM_W-1:0] x_reg;
    logic [c2s_pkg::NRM_W-1:0] x_next;
    logic [c2s_pkg::NRM_W-1:0] y_reg;
    logic [c2s_pkg::NRM_W-1:0] y_next;

    // The larger operand decides; OR-ing both gives the same leading one.
    always_comb
    begin
        hi_mask = ~({c2s_pkg::NRM_W{1'b1}} >> sh);
        move    = (((x_in | y_in) & hi_mask) == '0);
        x_next  = move ? (x_in << sh) : x_in;
        y_next  = move ? (y_in << sh) : y_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

// ===== hdl/c2s_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// c2s_cordic_cell: one vectoring CORDIC rotation
// Rotates toward the x axis and accumulates the rotation angle.
// ---------------------------------------------------------------------------
module c2s_cordic_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [c2s_pkg::STEP_W-1:0]        step,
    input  logic [c2s_pkg::TAB_W-1:0]         ang,
    input  logic signed [c2s_pkg::CX_W-1:0]   x_in,
    input  logic signed [c2s_pkg::CX_W-1:0]   y_in,
    input  logic signed [c2s_pkg::Z_W-1:0]    z_in,
    output logic signed [c2s_pkg::CX_W-1:0]   x_out,
    output logic signed [c2s_pkg::CX_W-1:0]   y_out,
    output logic signed [c2s_pkg::Z_W-1:0]    z_out
);

    logic signed [c2s_pkg::CX_W-1:0] xs;
    logic signed [c2s_pkg::CX_W-1:0] ys;
    logic signed [c2s_pkg::Z_W-1:0]  za;
    logic signed [c2s_pkg::CX_W-1:0] x_reg;
    logic signed [c2s_pkg::CX_W-1:0] x_next;
    logic signed [c2s_pkg::CX_W-1:0] y_reg;
    logic signed [c2s_pkg::CX_W-1:0] y_next;
    logic signed [c2s_pkg::Z_W-1:0]  z_reg;
    logic signed [c2s_pkg::Z_W-1:0]  z_next;

    always_comb
    begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        za = $signed({1'b0, ang});
        if (!y_in[c2s_pkg::CX_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + za;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - za;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== hdl/cartesian_to_spherical.sv =====
// ---------------------------------------------------------------------------
// cartesian_to_spherical: relative position to range, azimuth, elevation
// Pipelined square roots and vectoring CORDIC, one item per unstalled clock.
// ---------------------------------------------------------------------------
// Usage:
// An item on the pos channel carries a source and a target position. The
// sph channel returns one item per input item, in order: the rounded range,
// azimuth atan(dy/dx) and elevation asin(dz/range) in degrees with 16
// fraction bits, and a flag for an undefined azimuth (dx = dy = 0).
// Both channels use valid/ready. The pipeline accepts a new item every clock
// while the output register is free or being taken. Most of its length is
// the 53-cell square-root chain and the 40-cell CORDIC chain. When the
// receiver stalls, the whole pipeline holds and pos_ready drops in the same
// cycle; no item is lost.
// Reset clears all valid bits; no item is in flight afterwards, and the block
// accepts items in the first cycle after reset is released.
// ---------------------------------------------------------------------------
module cartesian_to_spherical (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pos_valid,
    output logic               pos_ready,
    input  c2s_pkg::c2s_pos_t  pos,
    output logic               sph_valid,
    input  logic               sph_ready,
    output c2s_pkg::c2s_sph_t  sph
);

    localparam int SQ_END   = c2s_pkg::SQ_STEPS;
    localparam int NRM_END  = SQ_END + c2s_pkg::NRM_STEPS;
    localparam int PREP     = NRM_END + 1;
    localparam int LINE     = PREP + c2s_pkg::CRD_STEPS + 1;
    localparam logic [c2s_pkg::ROOT_W:0] RNG_HALF =
        (c2s_pkg::ROOT_W + 1)'(1) << (c2s_pkg::SQ_FRAC - 1);
    localparam logic [c2s_pkg::Z_W:0] ANG_HALF =
        (c2s_pkg::Z_W + 1)'(1) << (c2s_pkg::RND_SH - 1);

    function automatic logic [c2s_pkg::ANG_W-1:0] round_angle(
        input logic signed [c2s_pkg::Z_W-1:0] z
    );
        logic [c2s_pkg::Z_W-1:0] mag;
        logic [c2s_pkg::Z_W:0]   rsum;
        logic [c2s_pkg::Z_W-c2s_pkg::RND_SH:0] r;
        logic [c2s_pkg::ANG_W-1:0] v;
        mag  = z[c2s_pkg::Z_W-1] ? (c2s_pkg::Z_W'(0) - z) : z;
        rsum = {1'b0, mag} + ANG_HALF;
        r    = rsum[c2s_pkg::Z_W:c2s_pkg::RND_SH];
        if (r > {{(c2s_pkg::Z_W + 1 - c2s_pkg::RND_SH - c2s_pkg::ANG_W){1'b0}},
                 c2s_pkg::RIGHT_ANGLE})
            v = c2s_pkg::RIGHT_ANGLE;
        else
            v = r[c2s_pkg::ANG_W-1:0];
        return z[c2s_pkg::Z_W-1] ? (c2s_pkg::ANG_W'(0) - v) : v;
    endfunction

    logic en;

    // Stage A: differences.
    logic                               va_reg;
    logic signed [c2s_pkg::DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [c2s_pkg::DIFF_W-1:0]  dx_next, dy_next, dz_next;

    // Stage B: squares and per-item facts.
    logic                               vb_reg;
    logic signed [2*c2s_pkg::DIFF_W-1:0] px, py, pz;
    logic [c2s_pkg::SQ_W-1:0]           sqx_reg, sqy_reg, sqz_reg;
    c2s_pkg::c2s_side_t                 side_b_reg;
    c2s_pkg::c2s_side_t                 side_b_next;

    // Stage C: sums of squares, registered at the head of the shift line.
    logic [c2s_pkg::R2_W-1:0]           h2_reg, r2_reg;
    logic [c2s_pkg::R2_W-1:0]           h2_next, r2_next;

    // Shift line of valid bits and item facts.
    logic                               ln_v_reg    [LINE];
    c2s_pkg::c2s_side_t                 ln_side_reg [LINE];
    logic                               ln_v_in     [LINE];
    c2s_pkg::c2s_side_t                 ln_side_in  [LINE];
    c2s_pkg::c2s_side_t                 side_rng;

    // Square-root lanes: h for the horizontal length, r for the range.
    logic [c2s_pkg::RAD_W-1:0]          qh_rad  [SQ_END+1];
    logic [c2s_pkg::ROOT_W-1:0]         qh_root [SQ_END+1];
    logic [c2s_pkg::REM_W-1:0]          qh_rem  [SQ_END+1];
    logic [c2s_pkg::RAD_W-1:0]          qr_rad  [SQ_END+1];
    logic [c2s_pkg::ROOT_W-1:0]         qr_root [SQ_END+1];
    logic [c2s_pkg::REM_W-1:0]          qr_rem  [SQ_END+1];
    logic [c2s_pkg::ROOT_W:0]           rsum_r;
    logic [c2s_pkg::RNG_W-1:0]          rng_w;

    // Normalization lanes: a for azimuth, e for elevation.
    logic [c2s_pkg::NRM_W-1:0]          na_x [c2s_pkg::NRM_STEPS+1];
    logic [c2s_pkg::NRM_W-1:0]          na_y [c2s_pkg::NRM_STEPS+1];
    logic [c2s_pkg::NRM_W-1:0]          ne_x [c2s_pkg::NRM_STEPS+1];
    logic [c2s_pkg::NRM_W-1:0]          ne_y [c2s_pkg::NRM_STEPS+1];

    // Signed CORDIC operands.
    logic signed [c2s_pkg::CX_W-1:0]    pa_x_reg, pa_y_reg, pe_x_reg, pe_y_reg;
    logic signed [c2s_pkg::CX_W-1:0]    pa_x_next, pa_y_next, pe_x_next, pe_y_next;
    logic signed [c2s_pkg::CX_W-1:0]    ya_pos, ye_pos;

    // CORDIC lanes.
    logic signed [c2s_pkg::CX_W-1:0]    ca_x [c2s_pkg::CRD_STEPS+1];
    logic signed [c2s_pkg::CX_W-1:0]    ca_y [c2s_pkg::CRD_STEPS+1];
    logic signed [c2s_pkg::Z_W-1:0]     ca_z [c2s_pkg::CRD_STEPS+1];
    logic signed [c2s_pkg::CX_W-1:0]    ce_x [c2s_pkg::CRD_STEPS+1];
    logic signed [c2s_pkg::CX_W-1:0]    ce_y [c2s_pkg::CRD_STEPS+1];
    logic signed [c2s_pkg::Z_W-1:0]     ce_z [c2s_pkg::CRD_STEPS+1];

    // Output register.
    logic                               out_v_reg;
    c2s_pkg::c2s_sph_t                  out_reg;
    c2s_pkg::c2s_sph_t                  out_next;
    c2s_pkg::c2s_side_t                 fin_side;
    logic                               undef;

    // The whole pipeline moves whenever the output register can take an item.
    assign en        = !out_v_reg || sph_ready;
    assign pos_ready = en;

    // ---------------- stage A ----------------
    always_comb
    begin
        dx_next = $signed({pos.dst_x[c2s_pkg::CRD_W-1], pos.dst_x})
                - $signed({pos.src_x[c2s_pkg::CRD_W-1], pos.src_x});
        dy_next = $signed({pos.dst_y[c2s_pkg::CRD_W-1], pos.dst_y})
                - $signed({pos.src_y[c2s_pkg::CRD_W-1], pos.src_y});
        dz_next = $signed({pos.dst_z[c2s_pkg::CRD_W-1], pos.dst_z})
                - $signed({pos.src_z[c2s_pkg::CRD_W-1], pos.src_z});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
    end

    // ---------------- stage B ----------------
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    always_comb
    begin
        side_b_next.ax = dx_reg[c2s_pkg::DIFF_W-1] ? c2s_pkg::DIFF_W'(-dx_reg) : dx_reg;
        side_b_next.ay = dy_reg[c2s_pkg::DIFF_W-1] ? c2s_pkg::DIFF_W'(-dy_reg) : dy_reg;
        side_b_next.az = dz_reg[c2s_pkg::DIFF_W-1] ? c2s_pkg::DIFF_W'(-dz_reg) : dz_reg;
        side_b_next.azi_neg = dx_reg[c2s_pkg::DIFF_W-1] ^ dy_reg[c2s_pkg::DIFF_W-1];
        side_b_next.dx_zero = (dx_reg == '0);
        side_b_next.dy_zero = (dy_reg == '0);
        side_b_next.dy_neg  = dy_reg[c2s_pkg::DIFF_W-1];
        side_b_next.dz_zero = (dz_reg == '0);
        side_b_next.dz_neg  = dz_reg[c2s_pkg::DIFF_W-1];
        side_b_next.rng     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= px[c2s_pkg::SQ_W-1:0];
            sqy_reg    <= py[c2s_pkg::SQ_W-1:0];
            sqz_reg    <= pz[c2s_pkg::SQ_W-1:0];
            side_b_reg <= side_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= pos_valid;
            vb_reg <= va_reg;
        end
    end

    // ---------------- stage C ----------------
    always_comb
    begin
        h2_next = c2s_pkg::R2_W'(sqx_reg) + c2s_pkg::R2_W'(sqy_reg);
        r2_next = h2_next + c2s_pkg::R2_W'(sqz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h2_reg <= h2_next;
            r2_reg <= r2_next;
        end
    end

    // ---------------- shift line ----------------
    // Round the range from the root with SQ_FRAC extra fraction bits; no
    // exact tie can occur for an integer radicand.
    always_comb
    begin
        rsum_r = {1'b0, qr_root[SQ_END]} + RNG_HALF;
        rng_w  = rsum_r[c2s_pkg::ROOT_W:c2s_pkg::SQ_FRAC];
        side_rng = ln_side_reg[SQ_END];
        if (rng_w > {{(c2s_pkg::RNG_W - c2s_pkg::RANGE_W){1'b0}},
                     {c2s_pkg::RANGE_W{1'b1}}})
            side_rng.rng = {c2s_pkg::RANGE_W{1'b1}};
        else
            side_rng.rng = rng_w[c2s_pkg::RANGE_W-1:0];
    end

    for (genvar p = 0; p < LINE; p++)
    begin : g_line
        if (p == 0)
        begin : g_head
            assign ln_v_in[p]    = vb_reg;
            assign ln_side_in[p] = side_b_reg;
        end
        else if (p == SQ_END + 1)
        begin : g_rng
            assign ln_v_in[p]    = ln_v_reg[p-1];
            assign ln_side_in[p] = side_rng;
        end
        else
        begin : g_mid
            assign ln_v_in[p]    = ln_v_reg[p-1];
            assign ln_side_in[p] = ln_side_reg[p-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ln_v_reg[p] <= 1'b0;
            else if (en)
                ln_v_reg[p] <= ln_v_in[p];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ln_side_reg[p] <= ln_side_in[p];
        end
    end

    // ---------------- square-root chains ----------------
    assign qh_rad[0]  = {h2_reg, {(2*c2s_pkg::SQ_FRAC){1'b0}}};
    assign qh_root[0] = '0;
    assign qh_rem[0]  = '0;
    assign qr_rad[0]  = {r2_reg, {(2*c2s_pkg::SQ_FRAC){1'b0}}};
    assign qr_root[0] = '0;
    assign qr_rem[0]  = '0;

    for (genvar k = 0; k < SQ_END; k++)
    begin : g_sqrt
        c2s_sqrt_cell u_sq_h (
            .clk      (clk),
            .en       (en),
            .rad_in   (qh_rad[k]),
            .root_in  (qh_root[k]),
            .rem_in   (qh_rem[k]),
            .rad_out  (qh_rad[k+1]),
            .root_out (qh_root[k+1]),
            .rem_out  (qh_rem[k+1])
        );
        c2s_sqrt_cell u_sq_r (
            .clk      (clk),
            .en       (en),
            .rad_in   (qr_rad[k]),
            .root_in  (qr_root[k]),
            .rem_in   (qr_rem[k]),
            .rad_out  (qr_rad[k+1]),
            .root_out (qr_root[k+1]),
            .rem_out  (qr_rem[k+1])
        );
    end

    // ---------------- normalization chains ----------------
    assign na_x[0] = {{(c2s_pkg::NRM_W - c2s_pkg::DIFF_W){1'b0}},
                      ln_side_reg[SQ_END].ax};
    assign na_y[0] = {{(c2s_pkg::NRM_W - c2s_pkg::DIFF_W){1'b0}},
                      ln_side_reg[SQ_END].ay};
    assign ne_x[0] = {{(c2s_pkg::NRM_W - c2s_pkg::ROOT_W){1'b0}}, qh_root[SQ_END]};
    assign ne_y[0] = {{(c2s_pkg::NRM_W - c2s_pkg::DIFF_W - c2s_pkg::SQ_FRAC){1'b0}},
                      ln_side_reg[SQ_END].az, {c2s_pkg::SQ_FRAC{1'b0}}};

    for (genvar k = 0; k < c2s_pkg::NRM_STEPS; k++)
    begin : g_norm
        c2s_norm_cell u_nrm_a (
            .clk   (clk),
            .en    (en),
            .sh    (c2s_pkg::NSH_W'(c2s_pkg::NRM_FIRST >> k)),
            .x_in  (na_x[k]),
            .y_in  (na_y[k]),
            .x_out (na_x[k+1]),
            .y_out (na_y[k+1])
        );
        c2s_norm_cell u_nrm_e (
            .clk   (clk),
            .en    (en),
            .sh    (c2s_pkg::NSH_W'(c2s_pkg::NRM_FIRST >> k)),
            .x_in  (ne_x[k]),
            .y_in  (ne_y[k]),
            .x_out (ne_x[k+1]),
            .y_out (ne_y[k+1])
        );
    end

    // ---------------- signed operands ----------------
    always_comb
    begin
        pa_x_next = $signed({{(c2s_pkg::CX_W - c2s_pkg::NRM_W){1'b0}},
                             na_x[c2s_pkg::NRM_STEPS]});
        ya_pos    = $signed({{(c2s_pkg::CX_W - c2s_pkg::NRM_W){1'b0}},
                             na_y[c2s_pkg::NRM_STEPS]});
        pa_y_next = ln_side_reg[NRM_END].azi_neg ? -ya_pos : ya_pos;
        pe_x_next = $signed({{(c2s_pkg::CX_W - c2s_pkg::NRM_W){1'b0}},
                             ne_x[c2s_pkg::NRM_STEPS]});
        ye_pos    = $signed({{(c2s_pkg::CX_W - c2s_pkg::NRM_W){1'b0}},
                             ne_y[c2s_pkg::NRM_STEPS]});
        pe_y_next = ln_side_reg[NRM_END].dz_neg ? -ye_pos : ye_pos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_x_reg <= pa_x_next;
            pa_y_reg <= pa_y_next;
            pe_x_reg <= pe_x_next;
            pe_y_reg <= pe_y_next;
        end
    end

    // ---------------- CORDIC chains ----------------
    assign ca_x[0] = pa_x_reg;
    assign ca_y[0] = pa_y_reg;
    assign ca_z[0] = '0;
    assign ce_x[0] = pe_x_reg;
    assign ce_y[0] = pe_y_reg;
    assign ce_z[0] = '0;

    for (genvar k = 0; k < c2s_pkg::CRD_STEPS; k++)
    begin : g_cordic
        c2s_cordic_cell u_cr_a (
            .clk   (clk),
            .en    (en),
            .step  (c2s_pkg::STEP_W'(k)),
            .ang   (c2s_pkg::atan_entry(k)),
            .x_in  (ca_x[k]),
            .y_in  (ca_y[k]),
            .z_in  (ca_z[k]),
            .x_out (ca_x[k+1]),
            .y_out (ca_y[k+1]),
            .z_out (ca_z[k+1])
        );
        c2s_cordic_cell u_cr_e (
            .clk   (clk),
            .en    (en),
            .step  (c2s_pkg::STEP_W'(k)),
            .ang   (c2s_pkg::atan_entry(k)),
            .x_in  (ce_x[k]),
            .y_in  (ce_y[k]),
            .z_in  (ce_z[k]),
            .x_out (ce_x[k+1]),
            .y_out (ce_y[k+1]),
            .z_out (ce_z[k+1])
        );
    end

    // ---------------- output register ----------------
    // Axis-aligned vectors get exact angles instead of the CORDIC estimate.
    always_comb
    begin
        fin_side = ln_side_reg[LINE-1];
        undef    = fin_side.dx_zero && fin_side.dy_zero;

        out_next.range_out      = fin_side.rng;
        out_next.undefined_flag = undef;

        if (fin_side.dy_zero)
            out_next.azimuth_deg = '0;
        else if (fin_side.dx_zero)
            out_next.azimuth_deg = fin_side.dy_neg ? c2s_pkg::NEG_RIGHT_ANGLE
                                                   : c2s_pkg::RIGHT_ANGLE;
        else
            out_next.azimuth_deg = round_angle(ca_z[c2s_pkg::CRD_STEPS]);

        if (fin_side.dz_zero)
            out_next.elevation_deg = '0;
        else if (undef)
            out_next.elevation_deg = fin_side.dz_neg ? c2s_pkg::NEG_RIGHT_ANGLE
                                                     : c2s_pkg::RIGHT_ANGLE;
        else
            out_next.elevation_deg = round_angle(ce_z[c2s_pkg::CRD_STEPS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= ln_v_reg[LINE-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign sph_valid = out_v_reg;
    assign sph       = out_reg;

endmodule

// ===== hdl/c2s_checker.sv =====
// ---------------------------------------------------------------------------
// c2s_checker: port-level checks of the Cartesian-to-spherical converter
// Watches the channels and the consistency of each result item.
// ---------------------------------------------------------------------------
module c2s_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pos_valid,
    input logic               pos_ready,
    input c2s_pkg::c2s_pos_t  pos,
    input logic               sph_valid,
    input logic               sph_ready,
    input c2s_pkg::c2s_sph_t  sph
);

    // A stalled result item stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sph_valid && !sph_ready |=> sph_valid && $stable(sph))
        else $error("result item changed while stalled");

    // A stalled output stops the intake in the same cycle.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        sph_valid && !sph_ready |-> !pos_ready)
        else $error("input taken while output stalled");

    // An undefined azimuth reads zero.
    a_undef_azi: assert property (@(posedge clk) disable iff (!rst_n)
        sph_valid && sph.undefined_flag |-> sph.azimuth_deg == '0)
        else $error("undefined azimuth not zero");

    // Zero range can only come from coincident positions.
    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        sph_valid && sph.range_out == '0 |-> sph.undefined_flag
            && sph.elevation_deg == '0)
        else $error("zero range without undefined flag");

    // A purely vertical vector points straight up or down.
    a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
        sph_valid && sph.undefined_flag && sph.range_out != '0 |->
            sph.elevation_deg == c2s_pkg::RIGHT_ANGLE
            || sph.elevation_deg == c2s_pkg::NEG_RIGHT_ANGLE)
        else $error("vertical vector elevation not +/-90");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
